FILE: hw/rtl/fenwick_2d_prefix_sum_core_defines.svh
// ----------------------------------------------------------------------------
// fenwick 2d prefix sum core assertion macros
// clocked concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef FENWICK_2D_PREFIX_SUM_CORE_DEFINES_SVH
`define FENWICK_2D_PREFIX_SUM_CORE_DEFINES_SVH

// assertion on an explicit clock and reset
`define FEN2D_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the block clock and reset
`define FEN2D_ASSERT(label, prop, msg) \
   `FEN2D_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

FILE: hw/rtl/fen2d_pkg.sv
// ----------------------------------------------------------------------------
// fen2d_pkg
// shared constants, codes and helpers of the 2d fenwick prefix sum core
// ----------------------------------------------------------------------------
package fen2d_pkg;

   // grid dimensions
   localparam int MAX_X  = 64;
   localparam int MAX_Y  = 64;
   localparam int DEPTH  = MAX_X * MAX_Y;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // field widths
   localparam int CRD_W  = 7;
   localparam int WLK_W  = CRD_W + 1;
   localparam int SUM_W  = 64;
   localparam int REQ_W  = 2;
   localparam int CSR_AW = 1;

   typedef logic [CRD_W-1:0] crd_type;
   typedef logic [WLK_W-1:0] wlk_type;
   typedef logic [SUM_W-1:0] sum_type;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PREFIX = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RECT   = 2'd2;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_SIZE_X = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_SIZE_Y = 1'd1;

   localparam crd_type SIZE_RESET = 7'd64;

   // lowest set bit
   function automatic wlk_type low_bit(input wlk_type v);
      return v & (~v + wlk_type'(1));
   endfunction

endpackage

FILE: hw/rtl/fenwick_2d_prefix_sum_core.sv
// ----------------------------------------------------------------------------
// fenwick_2d_prefix_sum_core
// two-dimensional binary indexed tree with point add, prefix and rectangle sums
// ----------------------------------------------------------------------------
// The tree lives in one single-port memory of MAX_X * MAX_Y 64-bit cells, and a
// small sequencer walks it through one shared 64-bit adder, one request at a
// time. After reset the memory is cleared one cell per cycle, and req_ready
// stays low until that pass ends; size registers may be written meanwhile. A
// point add reads and writes back each cell on the x and y update paths. A
// query reads one cell at a time along each prefix walk, and a rectangle
// query makes four such walks. A finished sum waits in the rsp register, and
// a new request is taken while it waits.
// ----------------------------------------------------------------------------
module fenwick_2d_prefix_sum_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fen2d_pkg::REQ_W-1:0]   req_type,
   input  logic [fen2d_pkg::CRD_W-1:0]   req_x_lo,
   input  logic [fen2d_pkg::CRD_W-1:0]   req_y_lo,
   input  logic [fen2d_pkg::CRD_W-1:0]   req_x_hi,
   input  logic [fen2d_pkg::CRD_W-1:0]   req_y_hi,
   input  logic signed [fen2d_pkg::SUM_W-1:0] req_delta,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [fen2d_pkg::SUM_W-1:0] rsp_sum,
   input  logic                          csr_we,
   input  logic [fen2d_pkg::CSR_AW-1:0]  csr_index,
   input  logic [fen2d_pkg::CRD_W-1:0]   csr_wdata
);
   import fen2d_pkg::*;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DECODE = 4'd2;
   localparam logic [3:0] ST_ARD    = 4'd3;
   localparam logic [3:0] ST_AWR    = 4'd4;
   localparam logic [3:0] ST_QSTART = 4'd5;
   localparam logic [3:0] ST_QRD    = 4'd6;
   localparam logic [3:0] ST_QACC   = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   crd_type           size_x_ff, size_y_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   sum_type           rsp_sum_ff, rsp_sum_in;

   logic [REQ_W-1:0]  op_ff;
   crd_type           xl_ff, yl_ff, xh_ff, yh_ff;
   sum_type           delta_ff;

   wlk_type           i_ff, i_in, j_ff, j_in;
   crd_type           xa_ff, xa_in, xb_ff, xb_in, ya_ff, ya_in, yb_ff, yb_in;
   logic [1:0]        k_ff, k_in, last_ff, last_in;
   sum_type           acc_ff, acc_in;

   sum_type           cell_mem [DEPTH];
   sum_type           rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   sum_type           mem_wdata;

   crd_type           nx, ny, xs, ys;
   crd_type           xl1, yl1, xhc, yhc;
   wlk_type           i_dn, j_dn, i_up, j_up;
   logic              sub_sel, add_sel;
   sum_type           op_a, op_b, add_res;

   // active sizes
   always_comb begin
      nx = (int'(size_x_ff) > MAX_X) ? CRD_W'(MAX_X) : size_x_ff;
      ny = (int'(size_y_ff) > MAX_Y) ? CRD_W'(MAX_Y) : size_y_ff;
   end

   // walk start of the current prefix term
   always_comb begin
      xs = k_ff[0] ? xb_ff : xa_ff;
      ys = k_ff[1] ? yb_ff : ya_ff;
   end

   // rectangle bounds
   always_comb begin
      xl1 = (xl_ff == '0) ? crd_type'(1) : xl_ff;
      yl1 = (yl_ff == '0) ? crd_type'(1) : yl_ff;
      xhc = (xh_ff > nx) ? nx : xh_ff;
      yhc = (yh_ff > ny) ? ny : yh_ff;
   end

   always_comb begin
      i_dn = i_ff - low_bit(i_ff);
      j_dn = j_ff - low_bit(j_ff);
      i_up = i_ff + low_bit(i_ff);
      j_up = j_ff + low_bit(j_ff);
   end

   // shared adder
   always_comb begin
      add_sel = (state_ff == ST_AWR);
      sub_sel = !add_sel && (k_ff[0] ^ k_ff[1]);
      op_a    = add_sel ? delta_ff : acc_ff;
      op_b    = sub_sel ? ~rd_data_ff : rd_data_ff;
      add_res = op_a + op_b + sum_type'(sub_sel);
   end

   // memory port
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_addr  = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = (state_ff == ST_AWR);
         mem_addr  = ADDR_W'((int'(i_ff) - 1) * MAX_Y + (int'(j_ff) - 1));
         mem_wdata = add_res;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= cell_mem[mem_addr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      ya_in        = ya_ff;
      yb_in        = yb_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            acc_in  = '0;
            k_in    = 2'd0;
            state_in = ST_IDLE;
            case (op_ff)
               REQ_ADD: begin
                  if (xh_ff != '0 && yh_ff != '0 && xh_ff <= nx && yh_ff <= ny) begin
                     i_in     = {1'b0, xh_ff};
                     j_in     = {1'b0, yh_ff};
                     ya_in    = yh_ff;
                     state_in = ST_ARD;
                  end
               end
               REQ_PREFIX: begin
                  xa_in    = xhc;
                  ya_in    = yhc;
                  xb_in    = '0;
                  yb_in    = '0;
                  last_in  = 2'd0;
                  state_in = ST_QSTART;
               end
               REQ_RECT: begin
                  xa_in   = xhc;
                  ya_in   = yhc;
                  xb_in   = xl1 - crd_type'(1);
                  yb_in   = yl1 - crd_type'(1);
                  last_in = 2'd3;
                  if (xl1 > xhc || yl1 > yhc) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_QSTART;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ARD: begin
            state_in = ST_AWR;
         end
         ST_AWR: begin
            state_in = ST_ARD;
            if (j_up > {1'b0, ny}) begin
               j_in = {1'b0, ya_ff};
               i_in = i_up;
               if (i_up > {1'b0, nx}) begin
                  state_in = ST_IDLE;
               end
            end else begin
               j_in = j_up;
            end
         end
         ST_QSTART: begin
            if (xs == '0 || ys == '0) begin
               if (k_ff == last_ff) begin
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               i_in     = {1'b0, xs};
               j_in     = {1'b0, ys};
               state_in = ST_QRD;
            end
         end
         ST_QRD: begin
            state_in = ST_QACC;
         end
         ST_QACC: begin
            acc_in   = add_res;
            state_in = ST_QRD;
            if (j_dn == '0) begin
               j_in = {1'b0, ys};
               i_in = i_dn;
               if (i_dn == '0) begin
                  if (k_ff == last_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     k_in     = k_ff + 2'd1;
                     state_in = ST_QSTART;
                  end
               end
            end else begin
               j_in = j_dn;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= 2'd0;
         last_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         last_ff      <= last_in;
      end
   end

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata;
            CSR_SIZE_Y: size_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff    <= req_type;
         xl_ff    <= req_x_lo;
         yl_ff    <= req_y_lo;
         xh_ff    <= req_x_hi;
         yh_ff    <= req_y_hi;
         delta_ff <= req_delta;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      xa_ff      <= xa_in;
      xb_ff      <= xb_in;
      ya_ff      <= ya_in;
      yb_ff      <= yb_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = $signed(rsp_sum_ff);

endmodule

FILE: hw/rtl/fen2d_checker.sv
// ----------------------------------------------------------------------------
// fen2d_checker
// port-level assertions for the 2d fenwick prefix sum core
// ----------------------------------------------------------------------------
`include "fenwick_2d_prefix_sum_core_defines.svh"

module fen2d_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [fen2d_pkg::SUM_W-1:0] rsp_sum
);

   // clearing pass holds off requests right after reset
   `FEN2D_ASSERT(a_clear_after_reset, $past(reset) |-> !req_ready, "ready during clear")

   // one request at a time
   `FEN2D_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "ready after accept")

   // a result only appears after the sequencer was busy
   `FEN2D_ASSERT(a_rsp_from_busy, $rose(rsp_valid) |-> $past(!req_ready), "result while idle")

   // stalled result holds
   `FEN2D_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sum)), "result dropped")

endmodule

bind fenwick_2d_prefix_sum_core fen2d_checker u_fen2d_checker (.*);

FILE: tb/fenwick_2d_prefix_sum_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_2d_prefix_sum_core_test
// Self-checking bench for the 2d fenwick prefix sum core. A directed request
// table covers the field extremes, ignored adds, clamped and empty queries,
// and then random request phases run under several grid sizes, 0, 1, 64 and
// 127 among them. Every sum is checked in order against a dense tree kept
// in the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module fenwick_2d_prefix_sum_core_test;
   import fen2d_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int      PHASES          = 8;
   localparam int      PHASE_REQUESTS  = 155;
   localparam int      SETTLE_CYCLES   = 400;
   localparam int      RSP_HOLD_CYCLES = 2500;
   localparam int      HOLD_AFTER_SUMS = 350;
   localparam int      QUIET_LIMIT     = 30000;
   localparam sum_type POS_MAX         = 64'h7fff_ffff_ffff_ffff;
   localparam sum_type NEG_MIN         = 64'h8000_0000_0000_0000;

   typedef struct {
      logic [REQ_W-1:0] kind;
      crd_type          x_lo;
      crd_type          y_lo;
      crd_type          x_hi;
      crd_type          y_hi;
      sum_type          delta;
      bit               fixed;
      sum_type          fixed_sum;
   } fen_request_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [REQ_W-1:0]         req_type;
   crd_type                  req_x_lo;
   crd_type                  req_y_lo;
   crd_type                  req_x_hi;
   crd_type                  req_y_hi;
   logic signed [SUM_W-1:0]  req_delta;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [SUM_W-1:0]  rsp_sum;
   logic                     csr_we;
   logic [CSR_AW-1:0]        csr_index;
   crd_type                  csr_wdata;

   sum_type         grid_cells [DEPTH];
   crd_type         cols_cfg;
   crd_type         rows_cfg;
   sum_type         expected_sums [$];
   fen_request_type directed_plan [$];
   sum_type         oldest_sum;
   int              fail_count   = 0;
   int              sums_checked = 0;
   bit              no_idle      = 1'b0;
   bit              hold_done    = 1'b0;

   fenwick_2d_prefix_sum_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_x_lo  (req_x_lo),
      .req_y_lo  (req_y_lo),
      .req_x_hi  (req_x_hi),
      .req_y_hi  (req_y_hi),
      .req_delta (req_delta),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_sum   (rsp_sum),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int active_cols();
      return (cols_cfg > MAX_X) ? MAX_X : int'(cols_cfg);
   endfunction

   function automatic int active_rows();
      return (rows_cfg > MAX_Y) ? MAX_Y : int'(rows_cfg);
   endfunction

   function automatic void apply_add(input int x, input int y, input sum_type d);
      int nx, ny, i, j;
      nx = active_cols();
      ny = active_rows();
      if (x == 0 || y == 0 || x > nx || y > ny)
         return;
      for (i = x; i <= nx; i += i & -i)
         for (j = y; j <= ny; j += j & -j)
            grid_cells[(i - 1) * MAX_Y + (j - 1)] += d;
   endfunction

   function automatic sum_type prefix_sum(input int x, input int y);
      int      i, j;
      sum_type s;
      s = '0;
      if (x > active_cols()) x = active_cols();
      if (y > active_rows()) y = active_rows();
      for (i = x; i > 0; i -= i & -i)
         for (j = y; j > 0; j -= j & -j)
            s += grid_cells[(i - 1) * MAX_Y + (j - 1)];
      return s;
   endfunction

   function automatic sum_type rect_sum(input int xl, input int yl,
                                        input int xh, input int yh);
      if (xl == 0) xl = 1;
      if (yl == 0) yl = 1;
      if (xl > xh || yl > yh)
         return '0;
      if (xh > active_cols()) xh = active_cols();
      if (yh > active_rows()) yh = active_rows();
      if (xl > xh || yl > yh)
         return '0;
      return prefix_sum(xh, yh) - prefix_sum(xl - 1, yh)
           - prefix_sum(xh, yl - 1) + prefix_sum(xl - 1, yl - 1);
   endfunction

   function automatic void plan_row(input logic [REQ_W-1:0] kind,
                                    input int xl, input int yl,
                                    input int xh, input int yh,
                                    input sum_type delta, input bit fixed);
      fen_request_type r;
      r.kind      = kind;
      r.x_lo      = crd_type'(xl);
      r.y_lo      = crd_type'(yl);
      r.x_hi      = crd_type'(xh);
      r.y_hi      = crd_type'(yh);
      r.delta     = delta;
      r.fixed     = fixed;
      r.fixed_sum = '0;
      directed_plan.push_back(r);
   endfunction

   function automatic crd_type pick_coord(input int n);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80 && n > 0)
         return crd_type'($urandom_range(1, n));
      else if (pick < 87)
         return '0;
      else if (pick < 94)
         return crd_type'($urandom_range(n + 1, 127));
      else
         return crd_type'($urandom_range(0, 127));
   endfunction

   function automatic fen_request_type random_request();
      fen_request_type r;
      int              pick, nx, ny;
      crd_type         a;
      nx   = active_cols();
      ny   = active_rows();
      pick = $urandom_range(0, 99);
      r.kind = (pick < 38) ? REQ_ADD : (pick < 68) ? REQ_PREFIX :
               (pick < 96) ? REQ_RECT : REQ_UNUSED;
      r.x_lo = crd_type'($urandom_range(0, 127));
      r.y_lo = crd_type'($urandom_range(0, 127));
      r.x_hi = pick_coord(nx);
      r.y_hi = pick_coord(ny);
      // mostly ordered rectangles
      if (r.kind == REQ_RECT && $urandom_range(0, 99) < 85) begin
         a = pick_coord(nx);
         if (a > r.x_hi) begin
            r.x_lo = r.x_hi;
            r.x_hi = a;
         end else begin
            r.x_lo = a;
         end
         a = pick_coord(ny);
         if (a > r.y_hi) begin
            r.y_lo = r.y_hi;
            r.y_hi = a;
         end else begin
            r.y_lo = a;
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.delta = longint'(int'($urandom_range(0, 2000)) - 1000);
      end else if (pick < 80) begin
         r.delta = {$urandom, $urandom};
      end else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0:       r.delta = POS_MAX;
            1:       r.delta = NEG_MIN;
            2:       r.delta = '1;
            default: r.delta = '0;
         endcase
      end else begin
         r.delta = sum_type'(1) << $urandom_range(0, 63);
      end
      r.fixed     = 1'b0;
      r.fixed_sum = '0;
      return r;
   endfunction

   task automatic send_request(input fen_request_type r);
      sum_type s;
      req_valid <= 1'b1;
      req_type  <= r.kind;
      req_x_lo  <= r.x_lo;
      req_y_lo  <= r.y_lo;
      req_x_hi  <= r.x_hi;
      req_y_hi  <= r.y_hi;
      req_delta <= r.delta;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      case (r.kind)
         REQ_ADD: begin
            apply_add(int'(r.x_hi), int'(r.y_hi), r.delta);
         end
         REQ_PREFIX, REQ_RECT: begin
            if (r.kind == REQ_PREFIX)
               s = prefix_sum(int'(r.x_hi), int'(r.y_hi));
            else
               s = rect_sum(int'(r.x_lo), int'(r.y_lo), int'(r.x_hi), int'(r.y_hi));
            expected_sums.push_back(r.fixed ? r.fixed_sum : s);
         end
         default: ;
      endcase
   endtask

   task automatic idle_between();
      if (!no_idle && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // wait out every pending sum plus any add still walking the tree
   task automatic drain();
      while (expected_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      crd_type sx, sy;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_type  <= REQ_ADD;
      req_x_lo  <= '0;
      req_y_lo  <= '0;
      req_x_hi  <= '0;
      req_y_hi  <= '0;
      req_delta <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_SIZE_X;
      csr_wdata <= '0;
      cols_cfg  = SIZE_RESET;
      rows_cfg  = SIZE_RESET;
      foreach (grid_cells[k])
         grid_cells[k] = '0;

      // kind, x_lo, y_lo, x_hi, y_hi, delta, fixed zero answer
      plan_row(REQ_PREFIX, 0, 0, 64, 64, '0, 1'b1);
      plan_row(REQ_RECT, 1, 1, 64, 64, '1, 1'b1);
      plan_row(REQ_ADD, 127, 127, 1, 1, POS_MAX, 1'b0);
      plan_row(REQ_ADD, 0, 0, 64, 64, NEG_MIN, 1'b0);
      plan_row(REQ_ADD, 0, 0, 0, 5, 64'd123, 1'b0);
      plan_row(REQ_ADD, 0, 0, 5, 0, 64'd77, 1'b0);
      plan_row(REQ_ADD, 0, 0, 65, 3, 64'd9, 1'b0);
      plan_row(REQ_ADD, 0, 0, 127, 127, '1, 1'b0);
      plan_row(REQ_PREFIX, 127, 127, 64, 64, '0, 1'b0);
      plan_row(REQ_PREFIX, 0, 0, 0, 10, '0, 1'b1);
      plan_row(REQ_PREFIX, 0, 0, 10, 0, '0, 1'b1);
      plan_row(REQ_PREFIX, 0, 0, 127, 127, '0, 1'b0);
      plan_row(REQ_RECT, 5, 1, 4, 64, '0, 1'b1);
      plan_row(REQ_RECT, 1, 9, 64, 8, '0, 1'b1);
      plan_row(REQ_RECT, 0, 0, 64, 64, '0, 1'b0);
      plan_row(REQ_RECT, 65, 1, 127, 64, '0, 1'b1);
      plan_row(REQ_RECT, 0, 0, 0, 0, '0, 1'b1);
      plan_row(REQ_ADD, 0, 0, 33, 17, -64'sd5, 1'b0);
      plan_row(REQ_ADD, 0, 0, 64, 1, 64'd1, 1'b0);
      plan_row(REQ_RECT, 33, 17, 64, 64, '0, 1'b0);
      plan_row(REQ_UNUSED, 7, 7, 7, 7, 64'd55, 1'b0);
      plan_row(REQ_PREFIX, 0, 0, 1, 1, '0, 1'b0);
      plan_row(REQ_RECT, 64, 64, 64, 64, '0, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k]) begin
         send_request(directed_plan[k]);
         idle_between();
      end

      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         drain();
         case (p)
            0:       begin sx = 7'd1;   sy = 7'd1;   end
            1:       begin sx = 7'd0;   sy = 7'd40;  end
            2:       begin sx = 7'd127; sy = 7'd127; end
            3:       begin sx = 7'd64;  sy = 7'd64;  end
            4:       begin sx = 7'd13;  sy = 7'd50;  end
            5:       begin sx = 7'd64;  sy = 7'd1;   end
            default: begin
               sx = crd_type'($urandom_range(0, 127));
               sy = crd_type'($urandom_range(0, 127));
            end
         endcase
         csr_we    <= 1'b1;
         csr_index <= CSR_SIZE_X;
         csr_wdata <= sx;
         @(posedge clock);
         csr_index <= CSR_SIZE_Y;
         csr_wdata <= sy;
         @(posedge clock);
         csr_we   <= 1'b0;
         cols_cfg = sx;
         rows_cfg = sy;
         no_idle  = (p == 3);
         repeat (PHASE_REQUESTS) begin
            send_request(random_request());
            idle_between();
         end
      end

      req_valid <= 1'b0;
      drain();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin : sink
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         // one long back-pressure stretch to fill the block
         if (!hold_done && sums_checked >= HOLD_AFTER_SUMS) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: sum with no request pending, expected none, actual %h",
                     $time, rsp_sum);
            fail_count++;
         end else begin
            oldest_sum = expected_sums.pop_front();
            if (rsp_sum !== oldest_sum) begin
               $display("%0t: sum mismatch, expected %h, actual %h",
                        $time, oldest_sum, rsp_sum);
               fail_count++;
            end
         end
         sums_checked++;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no request or sum moved for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
